// ===== rtl/i2cms_pkg.sv =====
// shared constants, codes and types of the i2c message sequencer
`default_nettype none

package i2cms_pkg;

  // storage sizes
  localparam int MAX_MESSAGES = 8;
  localparam int STORE_DEPTH  = 256;
  localparam int DIDX_W       = $clog2(MAX_MESSAGES);
  localparam int SADDR_W      = $clog2(STORE_DEPTH);
  localparam int MIDX_W       = 4;

  // request kinds
  localparam logic [2:0] REQ_LOAD   = 3'd0;
  localparam logic [2:0] REQ_WRBUF  = 3'd1;
  localparam logic [2:0] REQ_RDBUF  = 3'd2;
  localparam logic [2:0] REQ_BEGIN  = 3'd3;
  localparam logic [2:0] REQ_STATUS = 3'd4;

  // controller commands
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_SEND   = 3'd2;
  localparam logic [2:0] CMD_RECV   = 3'd3;
  localparam logic [2:0] CMD_FINISH = 3'd4;

  // sequencer phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_RADD  = 3'd1;
  localparam logic [2:0] PH_SADD  = 3'd2;
  localparam logic [2:0] PH_RDAT  = 3'd3;
  localparam logic [2:0] PH_SDAT  = 3'd4;

  // controller status codes
  localparam logic [7:0] ST_BUS_ERR  = 8'h00;
  localparam logic [7:0] ST_STA      = 8'h08;
  localparam logic [7:0] ST_REP_STA  = 8'h10;
  localparam logic [7:0] ST_SADD_ACK = 8'h18;
  localparam logic [7:0] ST_SDAT_ACK = 8'h28;
  localparam logic [7:0] ST_ARB_LOST = 8'h38;
  localparam logic [7:0] ST_RADD_ACK = 8'h40;
  localparam logic [7:0] ST_RDAT_ACK = 8'h50;

  // message descriptor as held in the table
  typedef struct packed {
    logic [7:0] base;
    logic [8:0] len;
    logic       rd;
    logic [6:0] addr;
  } desc_t;

  // one input request
  typedef struct packed {
    logic [2:0] req_type;
    logic [2:0] desc_index;
    logic [6:0] slave_addr;
    logic       read_flag;
    logic [8:0] msg_length;
    logic [7:0] buf_base;
    logic [7:0] buf_index;
    logic [7:0] write_byte;
    logic [3:0] msg_count;
    logic [7:0] status_code;
    logic [7:0] rx_byte;
  } in_item_t;

  // one result
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       transfer_done;
    logic       reset_flag;
    logic [3:0] messages_done;
    logic       busy_res;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/i2cms_in_if.sv =====
// request channel of the i2c message sequencer
`default_nettype none

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [2:0] desc_index;
  logic [6:0] slave_addr;
  logic       read_flag;
  logic [8:0] msg_length;
  logic [7:0] buf_base;
  logic [7:0] buf_index;
  logic [7:0] write_byte;
  logic [3:0] msg_count;
  logic [7:0] status_code;
  logic [7:0] rx_byte;

  modport source (
    output valid, req_type, desc_index, slave_addr, read_flag, msg_length,
           buf_base, buf_index, write_byte, msg_count, status_code, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, desc_index, slave_addr, read_flag, msg_length,
           buf_base, buf_index, write_byte, msg_count, status_code, rx_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/i2cms_out_if.sv =====
// result channel of the i2c message sequencer
`default_nettype none

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic [7:0] read_data;
  logic       transfer_done;
  logic       reset_flag;
  logic [3:0] messages_done;
  logic       busy_res;

  modport source (
    output valid, command, tx_byte, read_data, transfer_done, reset_flag,
           messages_done, busy_res,
    input  ready
  );
  modport sink (
    input  valid, command, tx_byte, read_data, transfer_done, reset_flag,
           messages_done, busy_res,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/i2c_message_sequencer.sv =====
// i2c multi-message transfer sequencer with descriptor table and byte store
//
// usage
//   in_chan carries requests: load descriptor, write buffer byte, read buffer
//   byte, begin transfer and controller status event. out_chan returns exactly
//   one result per request, in request order, with the controller command
//   to issue, the byte to send, any buffer byte read back and the status.
//   both channels move a request when valid and ready are high at a clock edge
// pipeline and flow
//   a request passes the input register, descriptor read, byte store read
//   and execute into the output register. load, write, read and begin
//   requests flow at one per cycle while out_chan is ready and no status
//   event waits ahead of them. a status event waits in the input register
//   until the two read stages ahead of it are empty, since its descriptor
//   and byte addresses follow from the state the previous request leaves;
//   consecutive status events therefore do not overlap in the pipe
// reset
//   synchronous active-low reset idles the sequencer and empties the pipe;
//   the descriptor table and byte store hold no defined value until written
// stalls
//   when out_chan is not ready the result stays in the output register,
//   the stages behind fill up and in_chan ready drops once the input
//   register is occupied
`default_nettype none

module i2c_message_sequencer
  import i2cms_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  i2cms_in_if.sink      in_chan,
  i2cms_out_if.source   out_chan
);

  // descriptor table and byte store, one synchronous read each
  desc_t      dsc_mem [MAX_MESSAGES];
  logic [7:0] byt_mem [STORE_DEPTH];

  // pipeline registers
  logic       p0_v_r, p1_v_r, p2_v_r, out_v_r;
  in_item_t   p0_r, p1_r, p2_r;
  desc_t      dsc_q_r, p2_dsc_r;
  logic [7:0] byt_q_r;
  logic       fwd_v_r;
  logic [7:0] fwd_d_r;
  out_item_t  out_r;

  // sequencer state
  logic [2:0]        phase_r, phase_nxt;
  logic              active_r, active_nxt;
  logic [MIDX_W-1:0] mi_r, mi_nxt;
  logic [8:0]        bp_r, bp_nxt;
  logic [MIDX_W-1:0] total_r, total_nxt;
  logic              rneed_r, rneed_nxt;

  // handshake and stage advance
  logic fire2, adv1, adv0, st_block, acc;
  in_item_t in_item;

  assign fire2    = p2_v_r && (!out_v_r || out_chan.ready);
  assign adv1     = p1_v_r && (!p2_v_r || fire2);
  // a status event needs the state of every request ahead of it
  assign st_block = (p0_r.req_type == REQ_STATUS) && (p1_v_r || p2_v_r);
  assign adv0     = p0_v_r && !st_block && (!p1_v_r || adv1);
  assign in_chan.ready = !p0_v_r || adv0;
  assign acc      = in_chan.valid && in_chan.ready;

  assign in_item = '{
    req_type:    in_chan.req_type,
    desc_index:  in_chan.desc_index,
    slave_addr:  in_chan.slave_addr,
    read_flag:   in_chan.read_flag,
    msg_length:  in_chan.msg_length,
    buf_base:    in_chan.buf_base,
    buf_index:   in_chan.buf_index,
    write_byte:  in_chan.write_byte,
    msg_count:   in_chan.msg_count,
    status_code: in_chan.status_code,
    rx_byte:     in_chan.rx_byte
  };

  // byte store read address in stage one
  logic [8:0]         sum1;
  logic [SADDR_W-1:0] rd_addr;
  assign sum1    = {1'b0, dsc_q_r.base} + bp_r;
  assign rd_addr = (p1_r.req_type == REQ_RDBUF) ? p1_r.buf_index[SADDR_W-1:0]
                                                : sum1[SADDR_W-1:0];

  // message byte slot of the executing request
  logic [8:0]         sum2;
  logic [SADDR_W-1:0] msg_addr;
  logic [7:0]         byt_data;
  assign sum2     = {1'b0, p2_dsc_r.base} + bp_r;
  assign msg_addr = sum2[SADDR_W-1:0];
  // a store write in the same cycle as the read wins over the stale data
  assign byt_data = fwd_v_r ? fwd_d_r : byt_q_r;

  // execute stage
  logic [2:0]         cmd;
  logic [7:0]         tx;
  logic [7:0]         rdd;
  logic               done;
  logic               wr_en, store_we;
  logic [SADDR_W-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               fin, fin_rst, nxt_msg;
  logic [MIDX_W-1:0]  cnt_sat, mi_inc;
  logic [8:0]         bp_inc;
  logic [7:0]         st;

  assign cnt_sat = (p2_r.msg_count > MIDX_W'(MAX_MESSAGES)) ? MIDX_W'(MAX_MESSAGES)
                                                            : p2_r.msg_count;
  assign mi_inc  = mi_r + 1'b1;
  assign bp_inc  = bp_r + 1'b1;
  assign st      = p2_r.status_code;

  always_comb begin
    phase_nxt  = phase_r;
    active_nxt = active_r;
    mi_nxt     = mi_r;
    bp_nxt     = bp_r;
    total_nxt  = total_r;
    rneed_nxt  = rneed_r;
    cmd        = CMD_NONE;
    tx         = 8'd0;
    rdd        = 8'd0;
    done       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = p2_r.buf_index[SADDR_W-1:0];
    wr_data    = p2_r.write_byte;
    fin        = 1'b0;
    fin_rst    = 1'b0;
    nxt_msg    = 1'b0;

    case (p2_r.req_type)
      REQ_WRBUF: begin
        wr_en = 1'b1;
      end
      REQ_RDBUF: begin
        rdd = byt_data;
      end
      REQ_BEGIN: begin
        total_nxt = cnt_sat;
        mi_nxt    = '0;
        bp_nxt    = 9'd0;
        phase_nxt = PH_START;
        rneed_nxt = 1'b0;
        if (cnt_sat == '0) begin
          fin = 1'b1;
        end else begin
          active_nxt = 1'b1;
          cmd        = CMD_START;
        end
      end
      REQ_STATUS: begin
        if (active_r) begin
          if (st == ST_ARB_LOST || st == ST_BUS_ERR) begin
            fin     = 1'b1;
            fin_rst = 1'b1;
          end else begin
            unique case (phase_r) inside
              PH_START: begin
                if (st == ST_STA || st == ST_REP_STA) begin
                  phase_nxt = p2_dsc_r.rd ? PH_RADD : PH_SADD;
                  cmd       = CMD_SEND;
                  tx        = {p2_dsc_r.addr, p2_dsc_r.rd};
                end else begin
                  fin = 1'b1;
                end
              end
              PH_RADD, PH_SADD: begin
                // address nack needs a controller reset
                if (st != ((phase_r == PH_RADD) ? ST_RADD_ACK : ST_SADD_ACK)) begin
                  fin     = 1'b1;
                  fin_rst = 1'b1;
                end else if (p2_dsc_r.len == 9'd0) begin
                  nxt_msg = 1'b1;
                end else if (phase_r == PH_RADD) begin
                  phase_nxt = PH_RDAT;
                  cmd       = CMD_RECV;
                end else begin
                  phase_nxt = PH_SDAT;
                  cmd       = CMD_SEND;
                  tx        = byt_data;
                  bp_nxt    = bp_inc;
                end
              end
              PH_RDAT: begin
                if (st == ST_RDAT_ACK) begin
                  wr_en   = 1'b1;
                  wr_addr = msg_addr;
                  wr_data = p2_r.rx_byte;
                  bp_nxt  = bp_inc;
                  if (bp_inc >= p2_dsc_r.len) begin
                    nxt_msg = 1'b1;
                  end else begin
                    cmd = CMD_RECV;
                  end
                end else begin
                  fin = 1'b1;
                end
              end
              PH_SDAT: begin
                if (st == ST_SDAT_ACK) begin
                  if (bp_r >= p2_dsc_r.len) begin
                    nxt_msg = 1'b1;
                  end else begin
                    cmd    = CMD_SEND;
                    tx     = byt_data;
                    bp_nxt = bp_inc;
                  end
                end else begin
                  fin = 1'b1;
                end
              end
              default: begin
                fin = 1'b1;
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    // advance to the next message or end the transfer
    if (nxt_msg) begin
      bp_nxt = 9'd0;
      mi_nxt = mi_inc;
      if (mi_inc >= total_r) begin
        fin = 1'b1;
      end else begin
        phase_nxt = PH_START;
        cmd       = CMD_START;
      end
    end

    if (fin) begin
      if (fin_rst) begin
        rneed_nxt = 1'b1;
      end
      active_nxt = 1'b0;
      cmd        = CMD_FINISH;
      done       = 1'b1;
    end
  end

  assign store_we = fire2 && wr_en;

  // descriptor table: read on leaving the input register, written on execute
  always_ff @(posedge clk) begin
    if (adv0) begin
      dsc_q_r <= dsc_mem[mi_r[DIDX_W-1:0]];
    end
    if (fire2 && p2_r.req_type == REQ_LOAD && int'(p2_r.desc_index) < MAX_MESSAGES) begin
      dsc_mem[p2_r.desc_index[DIDX_W-1:0]] <= '{
        base: p2_r.buf_base,
        len:  p2_r.msg_length,
        rd:   p2_r.read_flag,
        addr: p2_r.slave_addr
      };
    end
  end

  // byte store: read on leaving stage one, written on execute
  always_ff @(posedge clk) begin
    if (adv1) begin
      byt_q_r <= byt_mem[rd_addr];
      fwd_v_r <= store_we && (wr_addr == rd_addr);
      fwd_d_r <= wr_data;
    end
    if (store_we) begin
      byt_mem[wr_addr] <= wr_data;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (acc) begin
      p0_r <= in_item;
    end
    if (adv0) begin
      p1_r <= p0_r;
    end
    if (adv1) begin
      p2_r     <= p1_r;
      p2_dsc_r <= dsc_q_r;
    end
    if (fire2) begin
      out_r <= '{
        command:       cmd,
        tx_byte:       tx,
        read_data:     rdd,
        transfer_done: done,
        reset_flag:    rneed_nxt,
        messages_done: mi_nxt,
        busy_res:      active_nxt
      };
    end
  end

  // valid bits and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r   <= 1'b0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      phase_r  <= PH_START;
      active_r <= 1'b0;
      mi_r     <= '0;
      bp_r     <= 9'd0;
      total_r  <= '0;
      rneed_r  <= 1'b0;
    end else begin
      if (acc) begin
        p0_v_r <= 1'b1;
      end else if (adv0) begin
        p0_v_r <= 1'b0;
      end
      if (adv0) begin
        p1_v_r <= 1'b1;
      end else if (adv1) begin
        p1_v_r <= 1'b0;
      end
      if (adv1) begin
        p2_v_r <= 1'b1;
      end else if (fire2) begin
        p2_v_r <= 1'b0;
      end
      if (fire2) begin
        out_v_r  <= 1'b1;
        phase_r  <= phase_nxt;
        active_r <= active_nxt;
        mi_r     <= mi_nxt;
        bp_r     <= bp_nxt;
        total_r  <= total_nxt;
        rneed_r  <= rneed_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.command       = out_r.command;
  assign out_chan.tx_byte       = out_r.tx_byte;
  assign out_chan.read_data     = out_r.read_data;
  assign out_chan.transfer_done = out_r.transfer_done;
  assign out_chan.reset_flag    = out_r.reset_flag;
  assign out_chan.messages_done = out_r.messages_done;
  assign out_chan.busy_res      = out_r.busy_res;

endmodule

`default_nettype wire

// ===== test/i2cms_checker.sv =====
// checker for the i2c message sequencer: watches both channels, predicts and compares results
`timescale 1ns / 100ps

module i2cms_checker
  import i2cms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  i2cms_in_if  in_mon,
  i2cms_out_if out_mon,
  output int   fail_count,
  output int   pending,
  output int   results_checked,
  output int   transfers_ended,
  output int   resets_flagged
);

  // results still owed by the block, oldest first
  out_item_t  owed_results [$];

  // shadow of the sequencer state
  logic [2:0] phase;
  logic       busy;
  logic [6:0] msg_idx;
  logic [8:0] byte_ptr;
  logic [3:0] msg_total;
  logic       need_reset;
  desc_t      desc_tab [MAX_MESSAGES];
  logic [7:0] byte_mem [STORE_DEPTH];

  // command being built for the current request
  logic [2:0] cmd;
  logic [7:0] tx;
  logic       ended;

  task automatic end_transfer(input logic with_reset);
    if (with_reset) begin
      need_reset = 1'b1;
      resets_flagged++;
    end
    busy  = 1'b0;
    cmd   = CMD_FINISH;
    ended = 1'b1;
    transfers_ended++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    cmd = CMD_SEND;
    tx  = b;
  endtask

  task automatic advance_message();
    byte_ptr = '0;
    msg_idx  = msg_idx + 7'd1;
    if (msg_idx >= msg_total) begin
      end_transfer(1'b0);
    end else begin
      phase = PH_START;
      cmd   = CMD_START;
    end
  endtask

  task automatic take_status(input logic [7:0] st, input logic [7:0] rx);
    desc_t d;
    int    slot;
    d = '0;
    if (msg_idx < MAX_MESSAGES) d = desc_tab[msg_idx[DIDX_W-1:0]];
    slot = (d.base + byte_ptr) % STORE_DEPTH;
    if (st == ST_ARB_LOST || st == ST_BUS_ERR) begin
      end_transfer(1'b1);
    end else begin
      case (phase)
        PH_START: begin
          if (st == ST_STA || st == ST_REP_STA) begin
            phase = d.rd ? PH_RADD : PH_SADD;
            send_byte({d.addr, d.rd});
          end else begin
            end_transfer(1'b0);
          end
        end
        PH_RADD, PH_SADD: begin
          // address nack of either direction needs a controller reset
          if (st != ((phase == PH_RADD) ? ST_RADD_ACK : ST_SADD_ACK)) begin
            end_transfer(1'b1);
          end else if (d.len == 9'd0) begin
            advance_message();
          end else if (phase == PH_RADD) begin
            phase = PH_RDAT;
            cmd   = CMD_RECV;
          end else begin
            phase = PH_SDAT;
            send_byte(byte_mem[slot]);
            byte_ptr = byte_ptr + 9'd1;
          end
        end
        PH_RDAT: begin
          if (st == ST_RDAT_ACK) begin
            byte_mem[slot] = rx;
            byte_ptr = byte_ptr + 9'd1;
            if (byte_ptr >= d.len) advance_message();
            else cmd = CMD_RECV;
          end else begin
            end_transfer(1'b0);
          end
        end
        PH_SDAT: begin
          if (st == ST_SDAT_ACK) begin
            if (byte_ptr >= d.len) begin
              advance_message();
            end else begin
              send_byte(byte_mem[slot]);
              byte_ptr = byte_ptr + 9'd1;
            end
          end else begin
            end_transfer(1'b0);
          end
        end
        default: end_transfer(1'b0);
      endcase
    end
  endtask

  task automatic predict_result(input in_item_t r, output out_item_t res);
    logic [7:0] rd_byte;
    logic [3:0] n;
    cmd     = CMD_NONE;
    tx      = '0;
    ended   = 1'b0;
    rd_byte = '0;
    case (r.req_type)
      REQ_LOAD: begin
        if (r.desc_index < MAX_MESSAGES)
          desc_tab[r.desc_index] = '{base: r.buf_base, len: r.msg_length,
                                     rd: r.read_flag, addr: r.slave_addr};
      end
      REQ_WRBUF: byte_mem[r.buf_index % STORE_DEPTH] = r.write_byte;
      REQ_RDBUF: rd_byte = byte_mem[r.buf_index % STORE_DEPTH];
      REQ_BEGIN: begin
        n = (r.msg_count > MAX_MESSAGES) ? 4'(MAX_MESSAGES) : r.msg_count;
        msg_total  = n;
        msg_idx    = '0;
        byte_ptr   = '0;
        phase      = PH_START;
        need_reset = 1'b0;
        if (n == 4'd0) begin
          end_transfer(1'b0);
        end else begin
          busy = 1'b1;
          cmd  = CMD_START;
        end
      end
      REQ_STATUS: if (busy) take_status(r.status_code, r.rx_byte);
      default: ;
    endcase
    res.command       = cmd;
    res.tx_byte       = tx;
    res.read_data     = rd_byte;
    res.transfer_done = ended;
    res.reset_flag    = need_reset;
    res.messages_done = msg_idx[3:0];
    res.busy_res      = busy;
  endtask

  always @(posedge clk) begin
    in_item_t  req;
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      phase      = PH_START;
      busy       = 1'b0;
      msg_idx    = '0;
      byte_ptr   = '0;
      msg_total  = '0;
      need_reset = 1'b0;
      owed_results.delete();
    end else begin
      // results first: anything leaving now was requested earlier
      if (out_mon.valid && out_mon.ready) begin
        got = '{command: out_mon.command, tx_byte: out_mon.tx_byte,
                read_data: out_mon.read_data, transfer_done: out_mon.transfer_done,
                reset_flag: out_mon.reset_flag, messages_done: out_mon.messages_done,
                busy_res: out_mon.busy_res};
        if (owed_results.size() == 0) begin
          fail_count++;
          $error("result with no request outstanding");
        end else begin
          want = owed_results.pop_front();
          results_checked++;
          if (got.command !== want.command) begin
            fail_count++;
            $error("command: expected %0d, got %0d", want.command, got.command);
          end
          if (got.tx_byte !== want.tx_byte) begin
            fail_count++;
            $error("tx_byte: expected %0h, got %0h", want.tx_byte, got.tx_byte);
          end
          if (got.read_data !== want.read_data) begin
            fail_count++;
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
          end
          if (got.transfer_done !== want.transfer_done) begin
            fail_count++;
            $error("transfer_done: expected %0d, got %0d", want.transfer_done,
                   got.transfer_done);
          end
          if (got.reset_flag !== want.reset_flag) begin
            fail_count++;
            $error("reset_flag: expected %0d, got %0d", want.reset_flag, got.reset_flag);
          end
          if (got.messages_done !== want.messages_done) begin
            fail_count++;
            $error("messages_done: expected %0d, got %0d", want.messages_done,
                   got.messages_done);
          end
          if (got.busy_res !== want.busy_res) begin
            fail_count++;
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req = '{req_type: in_mon.req_type, desc_index: in_mon.desc_index,
                slave_addr: in_mon.slave_addr, read_flag: in_mon.read_flag,
                msg_length: in_mon.msg_length, buf_base: in_mon.buf_base,
                buf_index: in_mon.buf_index, write_byte: in_mon.write_byte,
                msg_count: in_mon.msg_count, status_code: in_mon.status_code,
                rx_byte: in_mon.rx_byte};
        predict_result(req, want);
        owed_results.push_back(want);
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== test/tb_i2c_message_sequencer.sv =====
// testbench top of the i2c message sequencer: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_i2c_message_sequencer;
  import i2cms_pkg::*;

  // status a controller reports for a write address nack
  localparam logic [7:0] ST_SADD_NACK = 8'h20;
  // requests in the random part, on top of the store fill and directed cases
  localparam int RANDOM_REQUESTS = 1050;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  i2cms_in_if  in_chan ();
  i2cms_out_if out_chan ();

  int fail_count;
  int pending;
  int results_checked;
  int transfers_ended;
  int resets_flagged;

  // what the stimulus knows of the loaded descriptors, to build legal sequences
  desc_t slot_desc [MAX_MESSAGES];
  int    requests_sent = 0;
  bit    tx_burst = 1'b0;
  bit    rx_burst = 1'b0;

  i2c_message_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  i2cms_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .transfers_ended (transfers_ended),
    .resets_flagged  (resets_flagged)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  // message lengths: mostly short, now and then near the 256 byte maximum
  function automatic logic [8:0] draw_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 9'($urandom_range(0, 4));
    else if (pick < 96) return 9'($urandom_range(5, 24));
    else return 9'($urandom_range(250, 256));
  endfunction

  // message counts: mostly a few, sometimes zero or beyond the table size
  function automatic int draw_count();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return $urandom_range(1, 4);
  endfunction

  // request of the given kind with every other field random
  function automatic in_item_t make_request(input logic [2:0] kind);
    in_item_t r;
    r.req_type    = kind;
    r.desc_index  = 3'($urandom_range(0, 7));
    r.slave_addr  = 7'($urandom_range(0, 127));
    r.read_flag   = 1'($urandom_range(0, 1));
    r.msg_length  = draw_length();
    r.buf_base    = 8'($urandom_range(0, 255));
    r.buf_index   = 8'($urandom_range(0, 255));
    r.write_byte  = 8'($urandom_range(0, 255));
    r.msg_count   = 4'($urandom_range(0, 15));
    r.status_code = 8'($urandom_range(0, 255));
    r.rx_byte     = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // present one request after a random gap and hold it until taken
  task automatic push_request(input in_item_t r);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.req_type    <= r.req_type;
    in_chan.desc_index  <= r.desc_index;
    in_chan.slave_addr  <= r.slave_addr;
    in_chan.read_flag   <= r.read_flag;
    in_chan.msg_length  <= r.msg_length;
    in_chan.buf_base    <= r.buf_base;
    in_chan.buf_index   <= r.buf_index;
    in_chan.write_byte  <= r.write_byte;
    in_chan.msg_count   <= r.msg_count;
    in_chan.status_code <= r.status_code;
    in_chan.rx_byte     <= r.rx_byte;
    if (r.req_type == REQ_LOAD && r.desc_index < MAX_MESSAGES)
      slot_desc[r.desc_index] = '{base: r.buf_base, len: r.msg_length,
                                  rd: r.read_flag, addr: r.slave_addr};
    requests_sent++;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // drop valid and hold off until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic load_slot(input int idx, input int addr, input int rd, input int len,
                           input int base);
    in_item_t r;
    r = make_request(REQ_LOAD);
    r.desc_index = 3'(idx);
    r.slave_addr = 7'(addr);
    r.read_flag  = 1'(rd);
    r.msg_length = 9'(len);
    r.buf_base   = 8'(base);
    push_request(r);
  endtask

  task automatic send_begin(input int count);
    in_item_t r;
    r = make_request(REQ_BEGIN);
    r.msg_count = 4'(count);
    push_request(r);
  endtask

  task automatic send_status(input logic [7:0] st);
    in_item_t r;
    r = make_request(REQ_STATUS);
    r.status_code = st;
    push_request(r);
  endtask

  // the status a healthy bus would report, or now and then a fault in its place:
  // arbitration loss, bus error, a restart while busy or any other code
  task automatic step_status(input logic [7:0] want, input int fault_pct, output bit ok);
    logic [7:0] code;
    ok = 1'b1;
    if ($urandom_range(0, 99) < fault_pct) begin
      ok = 1'b0;
      case ($urandom_range(0, 3))
        0: send_status(ST_ARB_LOST);
        1: send_status(ST_BUS_ERR);
        2: send_begin(draw_count());
        default: begin
          code = 8'($urandom_range(0, 255));
          if (code == want) code = ST_ARB_LOST;
          send_status(code);
        end
      endcase
    end else begin
      send_status(want);
    end
  endtask

  // one multi-message transfer following the loaded descriptors
  task automatic run_transfer(input int count, input int fault_pct);
    int    n;
    int    k;
    int    b;
    bit    ok;
    desc_t d;
    send_begin(count);
    n = (count > MAX_MESSAGES) ? MAX_MESSAGES : count;
    for (k = 0; k < n; k++) begin
      d = slot_desc[k];
      step_status($urandom_range(0, 1) ? ST_STA : ST_REP_STA, fault_pct, ok);
      if (!ok) return;
      step_status(d.rd ? ST_RADD_ACK : ST_SADD_ACK, fault_pct, ok);
      if (!ok) return;
      for (b = 0; b < d.len; b++) begin
        step_status(d.rd ? ST_RDAT_ACK : ST_SDAT_ACK, fault_pct, ok);
        if (!ok) return;
      end
    end
  endtask

  // receiver: random stall before each result, with stretches of none
  initial begin
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // main stimulus
  initial begin
    int       i;
    int       random_end;
    int       pick;
    in_item_t r;
    in_chan.valid       = 1'b0;
    in_chan.req_type    = REQ_LOAD;
    in_chan.desc_index  = '0;
    in_chan.slave_addr  = '0;
    in_chan.read_flag   = 1'b0;
    in_chan.msg_length  = '0;
    in_chan.buf_base    = '0;
    in_chan.buf_index   = '0;
    in_chan.write_byte  = '0;
    in_chan.msg_count   = '0;
    in_chan.status_code = '0;
    in_chan.rx_byte     = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fill the byte store and descriptor table so no read ever meets an unwritten entry
    for (i = 0; i < STORE_DEPTH; i++) begin
      r = make_request(REQ_WRBUF);
      r.buf_index = 8'(i);
      push_request(r);
    end
    for (i = 0; i < MAX_MESSAGES; i++)
      load_slot(i, $urandom_range(0, 127), $urandom_range(0, 1), $urandom_range(0, 4),
                $urandom_range(0, 255));

    // directed: status while idle, unused request code, empty transfer
    send_status(ST_STA);
    push_request(make_request(3'd7));
    send_begin(0);

    // write with buffer wrap, read of one byte, zero-length write
    load_slot(0, 127, 0, 2, 255);
    load_slot(1, 0, 1, 1, 128);
    load_slot(2, 85, 0, 0, 0);
    run_transfer(3, 0);
    r = make_request(REQ_RDBUF);
    r.buf_index = 8'd128;
    push_request(r);

    // saturated count, then arbitration loss
    send_begin(15);
    send_status(ST_STA);
    send_status(ST_ARB_LOST);
    // begin clears the reset need; address nack sets it again
    send_begin(1);
    send_status(ST_STA);
    send_status(ST_SADD_NACK);
    // unexpected status in the start phase
    send_begin(2);
    send_status(ST_SADD_ACK);
    // restart while busy, then bus error
    send_begin(1);
    send_begin(2);
    send_status(ST_BUS_ERR);

    drain_results();

    // random part: mostly legal transfers, some with faults, the rest noise
    random_end = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < random_end) begin
      if ($urandom_range(0, 99) < 60) begin
        repeat ($urandom_range(0, 3))
          load_slot($urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 1),
                    draw_length(),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(250, 255)
                                                : $urandom_range(0, 255));
        repeat ($urandom_range(0, 2)) push_request(make_request(REQ_WRBUF));
        run_transfer(draw_count(), ($urandom_range(0, 2) == 0) ? 12 : 0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) push_request(make_request(REQ_STATUS));
        else if (pick < 55) push_request(make_request(REQ_RDBUF));
        else if (pick < 70) push_request(make_request(REQ_WRBUF));
        else if (pick < 80) push_request(make_request(REQ_LOAD));
        else if (pick < 90) push_request(make_request(REQ_BEGIN));
        else push_request(make_request(3'($urandom_range(5, 7))));
      end
      if ($urandom_range(0, 59) == 0) drain_results();
    end

    // wind down: all results back, then a margin past the pipe depth
    drain_results();
    repeat (16) @(posedge clk);

    $display("%0d requests sent, %0d results checked", requests_sent, results_checked);
    $display("%0d transfers ended, %0d of them needing a controller reset",
             transfers_ended, resets_flagged);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
